[src/ilist_pkg.sv]
// Shared constants, types and codes for the indexed word list.
`timescale 1ns / 1ps

package ilist_pkg;

    // List geometry
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;

    // Transaction field widths
    localparam int MODE_W   = 3;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    localparam int IN_FIELDS_W  = MODE_W + POS_W + VALUE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + VALUE_W + 1 + POS_W + LEN_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Count and comparison widths
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    // Reduction tree: cells are gathered in groups of eight
    localparam int GROUP_SIZE = 8;
    localparam int GROUP_W    = $clog2(GROUP_SIZE);
    localparam int NUM_GROUPS = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GRP_IDX_W  = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int NUM_SLOTS  = NUM_GROUPS * GROUP_SIZE;

    // Operation codes
    typedef enum logic [MODE_W-1:0] {
        OP_INSERT      = 3'd0,
        OP_APPEND      = 3'd1,
        OP_READ        = 3'd2,
        OP_WRITE       = 3'd3,
        OP_REMOVE      = 3'd4,
        OP_REMOVE_LAST = 3'd5,
        OP_FIND        = 3'd6
    } t_op;

    // Status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REDUCE
    } t_state;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic load;        // take the operand word
        logic take_left;   // shift up: take the lower neighbor
        logic take_right;  // shift down: take the upper neighbor
        logic in_list;     // cell holds a live entry
        logic sel;         // cell drives the read bus
        logic find_en;     // compare against the operand
    } t_cell_ctrl;

endpackage

[src/ilist_cell.sv]
// One storage cell of the list: holds a word, shifts with its neighbors, compares.
`timescale 1ns / 1ps

module ilist_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ilist_pkg::t_cell_ctrl              i_ctrl,
    input  logic [ilist_pkg::DATA_WIDTH-1:0]   i_value,
    input  logic [ilist_pkg::DATA_WIDTH-1:0]   i_left,
    input  logic [ilist_pkg::DATA_WIDTH-1:0]   i_right,
    output logic [ilist_pkg::DATA_WIDTH-1:0]   o_data,
    output logic [ilist_pkg::DATA_WIDTH-1:0]   o_rd_data,
    output logic                               o_match
);

    logic [ilist_pkg::DATA_WIDTH-1:0] r_data;

    // Stored word: load, shift up or shift down
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_ctrl.load) begin
            r_data <= i_value;
        end else if (i_ctrl.take_left) begin
            r_data <= i_left;
        end else if (i_ctrl.take_right) begin
            r_data <= i_right;
        end
    end

    assign o_data    = r_data;
    assign o_rd_data = i_ctrl.sel ? r_data : '0;
    assign o_match   = i_ctrl.find_en && i_ctrl.in_list && (r_data == i_value);

endmodule

[src/ilist_group.sv]
// Registered reduction over eight cells: read bus OR and first-match encode.
`timescale 1ns / 1ps

module ilist_group (
    input  logic                                                     i_clk,
    input  logic                                                     i_en,
    input  logic [ilist_pkg::GROUP_SIZE-1:0][ilist_pkg::DATA_WIDTH-1:0] i_rd_data,
    input  logic [ilist_pkg::GROUP_SIZE-1:0]                         i_match,
    output logic [ilist_pkg::DATA_WIDTH-1:0]                         o_rd_data,
    output logic                                                     o_any,
    output logic [ilist_pkg::GROUP_W-1:0]                            o_first
);

    logic [ilist_pkg::DATA_WIDTH-1:0] n_rd_data;
    logic [ilist_pkg::GROUP_W-1:0]    n_first;
    logic [ilist_pkg::DATA_WIDTH-1:0] r_rd_data;
    logic                             r_any;
    logic [ilist_pkg::GROUP_W-1:0]    r_first;

    // At most one cell is selected, so an OR merges the read bus.
    // Scan from the top so the lowest match wins.
    always_comb begin
        n_rd_data = '0;
        n_first   = '0;
        for (int k = ilist_pkg::GROUP_SIZE - 1; k >= 0; k--) begin
            n_rd_data = n_rd_data | i_rd_data[k];
            if (i_match[k]) begin
                n_first = ilist_pkg::GROUP_W'(k);
            end
        end
    end

    // Capture in the execute cycle; hold while the result waits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_data <= n_rd_data;
            r_any     <= |i_match;
            r_first   <= n_first;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_any     = r_any;
    assign o_first   = r_first;

endmodule

[src/indexed_list_insert_remove_find_top.sv]
// Indexed word list top: sequencer, chain of storage cells and reduction tree.
// The result passes the execute and reduce states, then the output register.
// No new transaction is taken before the result loads; the sequencer runs one operation at a time
// and the read/find result passes one registered level of 8-cell groups.
// Shifts for insert and remove happen in the cell chain in the execute cycle.
// Reset (synchronous, active low) empties the list and clears every cell to zero.
`timescale 1ns / 1ps

module indexed_list_insert_remove_find_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [2:0] mode, [8:3] position, [40:9] item_value, rest zero
    input  logic [ilist_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [1:0] status, [33:2] read_value, [34] found, [40:35] found_position, [47:41] length
    output logic [ilist_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int DW = ilist_pkg::DATA_WIDTH;

    // Sequencer and operand registers
    ilist_pkg::t_state  r_state, n_state;
    ilist_pkg::t_op     r_mode;
    logic [ilist_pkg::POS_W-1:0]  r_pos;
    logic [DW-1:0]                r_val;
    logic [ilist_pkg::CNT_W-1:0]  r_count, n_count;

    // Execute-stage flags carried to the reduce stage
    ilist_pkg::t_status r_status, n_status;
    logic               r_rd_en, r_find_en;

    // Output register
    logic                          r_out_valid;
    ilist_pkg::t_status            r_out_status;
    logic [ilist_pkg::VALUE_W-1:0] r_out_read;
    logic                          r_out_found;
    logic [ilist_pkg::POS_W-1:0]   r_out_fpos;
    logic [ilist_pkg::LEN_W-1:0]   r_out_len;

    // Execute decode
    logic                          w_exec;
    logic [ilist_pkg::CMP_W-1:0]   w_pos_e, w_cnt_e, w_ld_idx, w_rd_idx;
    logic                          w_ld_en, w_up_en, w_dn_en, w_rd_en, w_find_en;
    logic                          w_accept, w_out_load;

    // Cell chain and reduction wiring
    logic [DW-1:0]                                  w_chain [ilist_pkg::DEPTH+2];
    logic [ilist_pkg::NUM_SLOTS-1:0][DW-1:0]        w_rd;
    logic [ilist_pkg::NUM_SLOTS-1:0]                w_match;
    logic [DW-1:0]                 w_grp_rd    [ilist_pkg::NUM_GROUPS];
    logic                          w_grp_any   [ilist_pkg::NUM_GROUPS];
    logic [ilist_pkg::GROUP_W-1:0] w_grp_first [ilist_pkg::NUM_GROUPS];

    // Final reduction
    logic [DW-1:0]                 w_rd_all;
    logic                          w_found;
    logic [ilist_pkg::POS_W-1:0]   w_fpos;

    assign s_axis_tready = (r_state == ilist_pkg::S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_exec        = (r_state == ilist_pkg::S_EXEC);
    assign w_out_load    = (r_state == ilist_pkg::S_REDUCE) && (!r_out_valid || m_axis_tready);

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ilist_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ilist_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = ilist_pkg::S_EXEC;
                end
            end
            ilist_pkg::S_EXEC: begin
                n_state = ilist_pkg::S_REDUCE;
            end
            ilist_pkg::S_REDUCE: begin
                if (w_out_load) begin
                    n_state = ilist_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ilist_pkg::S_IDLE;
            end
        endcase
    end

    // Capture the operands of an accepted transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= ilist_pkg::t_op'(s_axis_tdata[ilist_pkg::MODE_W-1:0]);
            r_pos  <= s_axis_tdata[ilist_pkg::MODE_W +: ilist_pkg::POS_W];
            r_val  <= DW'(s_axis_tdata[ilist_pkg::MODE_W + ilist_pkg::POS_W +:
                                       ilist_pkg::VALUE_W]);
        end
    end

    assign w_pos_e = ilist_pkg::CMP_W'(r_pos);
    assign w_cnt_e = ilist_pkg::CMP_W'(r_count);

    // Operation decode: status, new count and cell commands
    always_comb begin
        n_status  = ilist_pkg::ST_OK;
        n_count   = r_count;
        w_ld_en   = 1'b0;
        w_ld_idx  = w_pos_e;
        w_up_en   = 1'b0;
        w_dn_en   = 1'b0;
        w_rd_en   = 1'b0;
        w_rd_idx  = w_pos_e;
        w_find_en = 1'b0;
        case (r_mode)
            ilist_pkg::OP_INSERT: begin
                if (w_pos_e > w_cnt_e) begin
                    n_status = ilist_pkg::ST_RANGE;
                end else if (w_cnt_e >= ilist_pkg::CMP_W'(ilist_pkg::DEPTH)) begin
                    n_status = ilist_pkg::ST_FULL;
                end else begin
                    w_ld_en = 1'b1;
                    w_up_en = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            ilist_pkg::OP_APPEND: begin
                if (w_cnt_e >= ilist_pkg::CMP_W'(ilist_pkg::DEPTH)) begin
                    n_status = ilist_pkg::ST_FULL;
                end else begin
                    w_ld_en  = 1'b1;
                    w_ld_idx = w_cnt_e;
                    n_count  = r_count + 1'b1;
                end
            end
            ilist_pkg::OP_READ: begin
                if (w_pos_e >= w_cnt_e) begin
                    n_status = ilist_pkg::ST_RANGE;
                end else begin
                    w_rd_en = 1'b1;
                end
            end
            ilist_pkg::OP_WRITE: begin
                if (w_pos_e >= ilist_pkg::CMP_W'(ilist_pkg::DEPTH)) begin
                    n_status = ilist_pkg::ST_RANGE;
                end else begin
                    w_ld_en = 1'b1;
                    // write past the end grows the list; gap cells stay stale
                    if (w_pos_e >= w_cnt_e) begin
                        n_count = ilist_pkg::CNT_W'(w_pos_e + 1'b1);
                    end
                end
            end
            ilist_pkg::OP_REMOVE: begin
                if (r_count == '0) begin
                    n_status = ilist_pkg::ST_EMPTY;
                end else if (w_pos_e >= w_cnt_e) begin
                    n_status = ilist_pkg::ST_RANGE;
                end else begin
                    w_rd_en = 1'b1;
                    w_dn_en = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            ilist_pkg::OP_REMOVE_LAST: begin
                if (r_count == '0) begin
                    n_status = ilist_pkg::ST_EMPTY;
                end else begin
                    w_rd_en  = 1'b1;
                    w_rd_idx = w_cnt_e - 1'b1;
                    n_count  = r_count - 1'b1;
                end
            end
            ilist_pkg::OP_FIND: begin
                w_find_en = 1'b1;
            end
            default: begin
                // unused code: no operation
            end
        endcase
    end

    // Count and execute flags update at the end of the execute cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_status  <= ilist_pkg::ST_OK;
            r_rd_en   <= 1'b0;
            r_find_en <= 1'b0;
        end else if (w_exec) begin
            r_count   <= n_count;
            r_status  <= n_status;
            r_rd_en   <= w_rd_en;
            r_find_en <= w_find_en;
        end
    end

    // Chain ends carry zero
    assign w_chain[0]                     = '0;
    assign w_chain[ilist_pkg::DEPTH + 1]  = '0;

    // Cell chain, padded up to whole groups
    for (genvar c = 0; c < ilist_pkg::NUM_SLOTS; c++) begin : g_slot
        if (c < ilist_pkg::DEPTH) begin : g_cell
            localparam logic [ilist_pkg::CMP_W-1:0] C_IDX = ilist_pkg::CMP_W'(c);
            ilist_pkg::t_cell_ctrl w_ctrl;

            always_comb begin
                w_ctrl.load       = w_exec && w_ld_en && (C_IDX == w_ld_idx);
                w_ctrl.take_left  = w_exec && w_up_en && (C_IDX > w_pos_e)
                                    && (C_IDX <= w_cnt_e);
                w_ctrl.take_right = w_exec && w_dn_en && (C_IDX >= w_pos_e)
                                    && ((C_IDX + 1'b1) < w_cnt_e);
                w_ctrl.in_list    = (C_IDX < w_cnt_e);
                w_ctrl.sel        = w_exec && w_rd_en && (C_IDX == w_rd_idx);
                w_ctrl.find_en    = w_exec && w_find_en;
            end

            ilist_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (w_ctrl),
                .i_value   (r_val),
                .i_left    (w_chain[c]),
                .i_right   (w_chain[c + 2]),
                .o_data    (w_chain[c + 1]),
                .o_rd_data (w_rd[c]),
                .o_match   (w_match[c])
            );
        end else begin : g_pad
            assign w_rd[c]    = '0;
            assign w_match[c] = 1'b0;
        end
    end

    // First reduction level, registered per group in the execute cycle
    for (genvar g = 0; g < ilist_pkg::NUM_GROUPS; g++) begin : g_group
        ilist_group u_group (
            .i_clk     (i_clk),
            .i_en      (w_exec),
            .i_rd_data (w_rd[g * ilist_pkg::GROUP_SIZE +: ilist_pkg::GROUP_SIZE]),
            .i_match   (w_match[g * ilist_pkg::GROUP_SIZE +: ilist_pkg::GROUP_SIZE]),
            .o_rd_data (w_grp_rd[g]),
            .o_any     (w_grp_any[g]),
            .o_first   (w_grp_first[g])
        );
    end

    // Second reduction level across groups; lowest group wins
    always_comb begin
        w_rd_all = '0;
        w_found  = 1'b0;
        w_fpos   = '0;
        for (int g = ilist_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
            w_rd_all = w_rd_all | w_grp_rd[g];
            if (w_grp_any[g]) begin
                w_found = 1'b1;
                w_fpos  = ilist_pkg::POS_W'({ilist_pkg::GRP_IDX_W'(g), w_grp_first[g]});
            end
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_status <= r_status;
            r_out_read   <= r_rd_en ? ilist_pkg::VALUE_W'(w_rd_all) : '0;
            r_out_found  <= r_find_en && w_found;
            r_out_fpos   <= (r_find_en && w_found) ? w_fpos : '0;
            r_out_len    <= ilist_pkg::LEN_W'(r_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = ilist_pkg::OUT_TDATA_W'({r_out_len, r_out_fpos, r_out_found,
                                                   r_out_read, r_out_status});

`ifndef ASSERT_OFF
    // The count never exceeds the list depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ilist_pkg::CNT_W'(ilist_pkg::DEPTH))
        else $error("entry count above depth");

    // The count only moves at the end of the execute cycle
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ilist_pkg::S_EXEC) |=> $stable(r_count))
        else $error("entry count changed outside execute");

    // A stalled result holds the sequencer in reduce
    a_reduce_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ilist_pkg::S_REDUCE && r_out_valid && !m_axis_tready)
        |=> (r_state == ilist_pkg::S_REDUCE))
        else $error("result overwritten while stalled");

    // A reported match always comes with ok status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_found) |-> (r_out_status == ilist_pkg::ST_OK))
        else $error("match reported with error status");

    // Read and find never share one operation
    a_rd_find_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_rd_en && r_find_en))
        else $error("read and find both enabled");
`endif

endmodule

[bench/testbench.sv]
// Self-checking bench for the indexed word list: random and directed list operations.
`timescale 1ns / 1ps

module testbench;
    import ilist_pkg::*;

    localparam int RUN_LIMIT   = 200000;
    localparam int STORE_SLOTS = 4096;
    localparam int RAND_ITEMS  = 1400;
    localparam int PHASE_LEN   = 200;
    localparam int CALM_FROM   = 1500;
    localparam int CALM_TO     = 2600;
    localparam int IDLE_PCT    = 12;
    localparam logic [MODE_W-1:0] OP_UNUSED = 3'd7;

    // Command and result layouts, lowest field in the lowest bits
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   pos;
        logic [MODE_W-1:0]  mode;
    } list_cmd_t;

    typedef struct packed {
        logic [LEN_W-1:0]   length;
        logic [POS_W-1:0]   found_pos;
        logic               found;
        logic [VALUE_W-1:0] read_value;
        t_status            status;
    } list_result_t;

    typedef struct {
        list_cmd_t cmd;
        bit        drain_first;  // hold off until every result is back
    } queued_cmd_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic s_tready;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    indexed_list_insert_remove_find_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the list
    logic [DATA_WIDTH-1:0] shadow_words [DEPTH];
    int unsigned           shadow_count;

    queued_cmd_t  cmd_queue[$];
    queued_cmd_t  next_cmd;
    list_result_t expected_results [STORE_SLOTS];
    int n_sent = 0;
    int n_done = 0;
    int n_errors = 0;
    int cycle_count = 0;
    int plan_count = 0;   // list length as seen by the stimulus planner

    wire calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

    // Apply one operation to the shadow list and return what the block should report
    function automatic list_result_t apply_list_op(input list_cmd_t c);
        list_result_t r;
        int unsigned  cnt;
        int unsigned  p;
        int unsigned  i;
        r   = '0;
        cnt = shadow_count;
        p   = c.pos;
        case (c.mode)
            OP_INSERT: begin
                if (p > cnt) begin
                    r.status = ST_RANGE;
                end else if (cnt >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = cnt; i > p; i--) shadow_words[i] = shadow_words[i - 1];
                    shadow_words[p] = c.value[DATA_WIDTH-1:0];
                    shadow_count = cnt + 1;
                end
            end
            OP_APPEND: begin
                if (cnt >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_words[cnt] = c.value[DATA_WIDTH-1:0];
                    shadow_count = cnt + 1;
                end
            end
            OP_READ: begin
                if (p >= cnt) r.status = ST_RANGE;
                else r.read_value = shadow_words[p];
            end
            OP_WRITE: begin
                if (p >= DEPTH) begin
                    r.status = ST_RANGE;
                end else begin
                    shadow_words[p] = c.value[DATA_WIDTH-1:0];
                    if (p >= cnt) shadow_count = p + 1;
                end
            end
            OP_REMOVE, OP_REMOVE_LAST: begin
                if (cnt == 0) begin
                    r.status = ST_EMPTY;
                end else if (c.mode == OP_REMOVE && p >= cnt) begin
                    r.status = ST_RANGE;
                end else begin
                    if (c.mode == OP_REMOVE_LAST) p = cnt - 1;
                    r.read_value = shadow_words[p];
                    // entries above move down; the vacated top cell keeps its word
                    for (i = p; i + 1 < cnt; i++) shadow_words[i] = shadow_words[i + 1];
                    shadow_count = cnt - 1;
                end
            end
            OP_FIND: begin
                for (i = 0; i < cnt; i++) begin
                    if (shadow_words[i] == c.value[DATA_WIDTH-1:0]) begin
                        r.found     = 1'b1;
                        r.found_pos = i[POS_W-1:0];
                        break;
                    end
                end
            end
            default: ;
        endcase
        r.length = shadow_count[LEN_W-1:0];
        return r;
    endfunction

    // Queue one command and follow the list length it leads to
    task automatic add_cmd(input logic [MODE_W-1:0] m, input int p,
                           input logic [VALUE_W-1:0] v, input bit drain_first);
        queued_cmd_t q;
        q.cmd.mode    = m;
        q.cmd.pos     = p[POS_W-1:0];
        q.cmd.value   = v;
        q.drain_first = drain_first;
        cmd_queue.push_back(q);
        case (m)
            OP_INSERT:      if (p <= plan_count && plan_count < DEPTH) plan_count++;
            OP_APPEND:      if (plan_count < DEPTH) plan_count++;
            OP_WRITE:       if (p >= plan_count) plan_count = p + 1;
            OP_REMOVE:      if (plan_count != 0 && p < plan_count) plan_count--;
            OP_REMOVE_LAST: if (plan_count != 0) plan_count--;
            default: ;
        endcase
    endtask

    // Driver: predict on each accepted transaction, then present the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results[n_sent] = apply_list_op(list_cmd_t'(s_tdata[IN_FIELDS_W-1:0]));
                n_sent <= n_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (cmd_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT) &&
                    (!cmd_queue[0].drain_first ||
                     n_done == n_sent + ((s_tvalid && s_tready) ? 1 : 0))) begin
                    next_cmd = cmd_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(IN_TDATA_W-IN_FIELDS_W){1'b0}}, next_cmd.cmd};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Monitor: compare each result transaction with the oldest expectation
    list_result_t seen_result;
    list_result_t want_result;
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            seen_result = list_result_t'(m_tdata[OUT_FIELDS_W-1:0]);
            if (n_done >= n_sent) begin
                $display("%0t: unexpected result, expected none, got %h", $time, seen_result);
                n_errors++;
            end else begin
                want_result = expected_results[n_done];
                if (seen_result.status !== want_result.status) begin
                    $display("%0t: status expected %0d got %0d", $time,
                             want_result.status, seen_result.status);
                    n_errors++;
                end
                if (seen_result.read_value !== want_result.read_value) begin
                    $display("%0t: read_value expected %h got %h", $time,
                             want_result.read_value, seen_result.read_value);
                    n_errors++;
                end
                if (seen_result.found !== want_result.found) begin
                    $display("%0t: found expected %0d got %0d", $time,
                             want_result.found, seen_result.found);
                    n_errors++;
                end
                if (seen_result.found_pos !== want_result.found_pos) begin
                    $display("%0t: found_position expected %0d got %0d", $time,
                             want_result.found_pos, seen_result.found_pos);
                    n_errors++;
                end
                if (seen_result.length !== want_result.length) begin
                    $display("%0t: length expected %0d got %0d", $time,
                             want_result.length, seen_result.length);
                    n_errors++;
                end
                n_done <= n_done + 1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus plan, reset and end of run
    initial begin
        logic [VALUE_W-1:0] pool [8];
        int                 cut [7];
        int                 kind;
        int                 r;
        int                 p;
        int                 n;
        logic [MODE_W-1:0]  m;
        logic [VALUE_W-1:0] v;

        foreach (shadow_words[k]) shadow_words[k] = '0;
        shadow_count = 0;

        // Directed: empty list, edges of the index range, full list, stale cells
        add_cmd(OP_UNUSED,      0,  '0,            1'b0);
        add_cmd(OP_READ,        0,  '0,            1'b0);
        add_cmd(OP_REMOVE,      0,  '0,            1'b0);
        add_cmd(OP_REMOVE_LAST, 0,  '0,            1'b0);
        add_cmd(OP_FIND,        0,  '0,            1'b0);
        add_cmd(OP_INSERT,      1,  32'h1111_1111, 1'b0);
        add_cmd(OP_INSERT,      0,  32'h0000_0000, 1'b0);
        add_cmd(OP_APPEND,      0,  32'hFFFF_FFFF, 1'b0);
        add_cmd(OP_INSERT,      2,  32'h8000_0001, 1'b0);
        add_cmd(OP_INSERT,      1,  32'h5A5A_A5A5, 1'b0);
        add_cmd(OP_READ,        63, '0,            1'b0);
        add_cmd(OP_READ,        3,  '0,            1'b0);
        add_cmd(OP_WRITE,       63, 32'hDEAD_BEEF, 1'b0);
        add_cmd(OP_READ,        40, '0,            1'b0);
        add_cmd(OP_APPEND,      0,  32'h0BAD_F00D, 1'b0);
        add_cmd(OP_INSERT,      0,  32'h0BAD_F00D, 1'b0);
        add_cmd(OP_INSERT,      63, 32'h0BAD_F00D, 1'b0);
        add_cmd(OP_FIND,        0,  32'hFFFF_FFFF, 1'b0);
        add_cmd(OP_FIND,        0,  32'h1234_5678, 1'b0);
        add_cmd(OP_REMOVE,      63, '0,            1'b0);
        add_cmd(OP_REMOVE,      0,  '0,            1'b0);
        add_cmd(OP_REMOVE_LAST, 0,  '0,            1'b0);
        add_cmd(OP_REMOVE,      62, '0,            1'b0);
        add_cmd(OP_WRITE,       0,  32'hC3C3_3C3C, 1'b0);
        add_cmd(OP_UNUSED,      63, 32'hFFFF_FFFF, 1'b0);

        // Value pool so that finds hit and duplicates occur
        pool[0] = '0;
        pool[1] = '1;
        for (n = 2; n < 8; n++) pool[n] = $urandom;

        // Random phases: growing, shrinking or balanced, each after a full drain
        kind = 0;
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n % PHASE_LEN == 0) begin
                kind = $urandom_range(0, 2);
                case (kind)
                    0:       cut = '{25, 45, 55, 70, 85, 92, 98};
                    1:       cut = '{8, 14, 18, 33, 48, 73, 98};
                    default: cut = '{15, 28, 36, 52, 68, 82, 98};
                endcase
            end
            r = $urandom_range(0, 99);
            m = (r < cut[0]) ? OP_INSERT :
                (r < cut[1]) ? OP_APPEND :
                (r < cut[2]) ? OP_WRITE :
                (r < cut[3]) ? OP_READ :
                (r < cut[4]) ? OP_FIND :
                (r < cut[5]) ? OP_REMOVE :
                (r < cut[6]) ? OP_REMOVE_LAST : OP_UNUSED;
            if ($urandom_range(0, 4) == 0) begin
                p = $urandom_range(0, 63);
            end else if (m == OP_INSERT) begin
                p = $urandom_range(0, (plan_count > 63) ? 63 : plan_count);
            end else if (m == OP_WRITE) begin
                p = $urandom_range(0, (plan_count + 2 > 63) ? 63 : plan_count + 2);
            end else begin
                p = (plan_count == 0) ? 0 : $urandom_range(0, plan_count - 1);
            end
            v = $urandom_range(0, 1) ? pool[$urandom_range(0, 7)] : $urandom;
            add_cmd(m, p, v, n % PHASE_LEN == 0);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last transaction to go out and every result to return
        while (cmd_queue.size() != 0 || s_tvalid || n_done != n_sent) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
